### sv/qsed_pkg.sv
// Shared types, character codes and helpers for the quoted-string escape decoder.
`default_nettype none

package qsed_pkg;

    // Character codes
    localparam logic [7:0] CH_N       = 8'h6E;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_R       = 8'h72;
    localparam logic [7:0] CH_F       = 8'h66;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_SEVEN   = 8'h37;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_FF      = 8'h0C;

    localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;
    // Result buffer depth and the widest push from one input beat
    localparam logic [1:0] OBUF_DEPTH     = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_string;
        logic       last_of_run;
    } out_item_t;

    // Results handed from the decoder to the result buffer in one cycle
    typedef struct packed {
        logic [1:0] count;
        out_item_t  res0;
        out_item_t  res1;
    } dec_push_t;

    function automatic logic is_octal(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_SEVEN);
    endfunction

    function automatic out_item_t mk_item(input logic [7:0] b, input logic v);
        out_item_t r;
        r.out_byte      = b;
        r.byte_valid    = v;
        r.end_of_string = 1'b0;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/quoted_string_escape_decoder_top.sv
// Top level of the quoted-string escape decoder: input register, decoder and result buffer.
//
// Input channel s_valid/s_ready/s_data carries one byte of a quoted string per
// beat, with last_byte set on the final byte. Result channel m_valid/m_ready/
// m_data carries decoded characters; last_of_run marks the final result of an
// input beat and end_of_string the final result of the string. A beat may make
// no result (quotes, the backslash, octal digits still building up) or two (a
// closing octal value followed by the byte that ended it).
// With the result buffer empty, a beat is held in the input register and its
// first result then in the result buffer, which drives m_data. Throughput: one
// beat per cycle while each beat makes at most one result and m_ready stays high.
// Room is checked against the buffer count before this cycle's pop, so while results
// stream a two-result beat waits for the buffer to empty and the next beat waits
// while the pair drains; from an empty buffer only the second wait remains.
// s_ready depends on registers only, so there is no combinational path from
// m_ready to s_ready. When the receiver stalls, the result buffer fills, the
// input register holds its beat and s_ready falls.
// Synchronous active-low reset empties both registers, drops any pending
// escape and returns the decoder to normal mode; the block is ready at once.
`default_nettype none

module quoted_string_escape_decoder_top
    import qsed_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    logic       in_valid_reg, in_valid_next;
    in_item_t   in_item_reg;
    logic       dec_fire;
    logic [1:0] obuf_count;
    dec_push_t  push;
    logic       s_fire;

    assign s_ready = !in_valid_reg || dec_fire;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (dec_fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg <= s_data;
        end
    end

    qsed_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (in_valid_reg),
        .item       (in_item_reg),
        .obuf_count (obuf_count),
        .fire       (dec_fire),
        .push       (push)
    );

    qsed_obuf u_obuf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .count   (obuf_count),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

### sv/qsed_decode.sv
// Escape decode logic and decoder state: turns one input beat into zero to two results.
`default_nettype none

module qsed_decode
    import qsed_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      item_valid,
    input  wire in_item_t  item,
    input  wire logic [1:0] obuf_count,
    output logic           fire,
    output dec_push_t      push
);

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESCAPE = 2'd1,
        MODE_OCTAL  = 2'd2
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [7:0] acc_reg, acc_next;

    logic       emit_a, emit_b, emit_c;
    logic [7:0] val_a, val_b, val_c;
    logic [1:0] n_res;
    out_item_t  res0, res1;

    always_comb begin
        logic       consumed;
        logic [7:0] b;
        logic [7:0] acc_sum;
        logic [1:0] cnt_inc;
        mode_t      mode_v;
        logic [1:0] cnt_v;
        logic [7:0] acc_v;

        b        = item.in_byte;
        mode_v   = mode_reg;
        cnt_v    = cnt_reg;
        acc_v    = acc_reg;
        consumed = 1'b0;
        emit_a   = 1'b0;
        emit_b   = 1'b0;
        emit_c   = 1'b0;
        val_a    = acc_reg;
        val_b    = b;
        acc_sum  = {acc_reg[4:0], 3'b000} + (b - CH_ZERO);
        cnt_inc  = cnt_reg + 2'd1;

        // Octal escape in progress: take a digit, or close it and fall through
        if (mode_reg == MODE_OCTAL) begin
            if (is_octal(b) && (cnt_reg < OCT_MAX_DIGITS)) begin
                consumed = 1'b1;
                if (cnt_inc >= OCT_MAX_DIGITS) begin
                    emit_a = (acc_sum != 8'd0);
                    val_a  = acc_sum;
                    mode_v = MODE_NORMAL;
                    cnt_v  = 2'd0;
                    acc_v  = 8'd0;
                end else begin
                    acc_v = acc_sum;
                    cnt_v = cnt_inc;
                end
            end else begin
                emit_a = (acc_reg != 8'd0);
                mode_v = MODE_NORMAL;
                cnt_v  = 2'd0;
                acc_v  = 8'd0;
            end
        end

        if (!consumed) begin
            if (mode_v == MODE_ESCAPE) begin
                mode_v = MODE_NORMAL;
                priority if (b == CH_N) begin
                    emit_b = 1'b1;
                    val_b  = CH_LF;
                end else if (b == CH_T) begin
                    emit_b = 1'b1;
                    val_b  = CH_TAB;
                end else if (b == CH_R) begin
                    emit_b = 1'b1;
                    val_b  = CH_CR;
                end else if (b == CH_F) begin
                    emit_b = 1'b1;
                    val_b  = CH_FF;
                end else if (is_octal(b)) begin
                    mode_v = MODE_OCTAL;
                    acc_v  = b - CH_ZERO;
                    cnt_v  = 2'd1;
                end else begin
                    emit_b = 1'b1;
                end
            end else begin
                mode_v = MODE_NORMAL;
                priority if (b == CH_QUOTE) begin
                    // drop
                end else if (b == CH_BSLASH) begin
                    mode_v = MODE_ESCAPE;
                end else begin
                    emit_b = 1'b1;
                end
            end
        end

        // Last beat flushes a pending octal value and returns to reset state
        val_c = acc_v;
        if (item.last_byte) begin
            emit_c = (mode_v == MODE_OCTAL) && (acc_v != 8'd0);
            mode_v = MODE_NORMAL;
            cnt_v  = 2'd0;
            acc_v  = 8'd0;
        end

        mode_next = mode_v;
        cnt_next  = cnt_v;
        acc_next  = acc_v;
    end

    // Order the results, give a last beat that makes none an empty result, and tag the final one
    always_comb begin
        res0  = mk_item(val_c, emit_c);
        res1  = mk_item(val_c, emit_c);
        n_res = {1'b0, emit_a} + {1'b0, emit_b} + {1'b0, emit_c};
        if (emit_a) begin
            res0 = mk_item(val_a, 1'b1);
            if (emit_b) begin
                res1 = mk_item(val_b, 1'b1);
            end
        end else if (emit_b) begin
            res0 = mk_item(val_b, 1'b1);
        end
        if ((n_res == 2'd0) && item.last_byte) begin
            res0  = mk_item(8'd0, 1'b0);
            n_res = 2'd1;
        end
        if (n_res == 2'd2) begin
            res1.last_of_run   = 1'b1;
            res1.end_of_string = item.last_byte;
        end else begin
            res0.last_of_run   = 1'b1;
            res0.end_of_string = item.last_byte;
        end
    end

    // Hold the beat until the result buffer can take every result it makes
    assign fire = item_valid && (({1'b0, obuf_count} + {1'b0, n_res}) <= {1'b0, OBUF_DEPTH});

    always_comb begin
        push.count = fire ? n_res : 2'd0;
        push.res0  = res0;
        push.res1  = res1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORMAL;
            cnt_reg  <= 2'd0;
            acc_reg  <= 8'd0;
        end else if (fire) begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            acc_reg  <= acc_next;
        end
    end

    a_last_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && item.last_byte) |=> (mode_reg == MODE_NORMAL && cnt_reg == 2'd0
                                      && acc_reg == 8'd0))
        else $error("decoder state not cleared after last beat");

    a_octal_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_OCTAL) |-> (cnt_reg == 2'd1 || cnt_reg == 2'd2))
        else $error("octal digit count out of range in octal mode");

endmodule

`default_nettype wire

### sv/qsed_obuf.sv
// Two-entry result buffer that drives the result channel one beat per cycle while m_ready is high.
`default_nettype none

module qsed_obuf
    import qsed_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire dec_push_t push,
    output logic [1:0]     count,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    out_item_t  slot_reg [2];
    out_item_t  slot_next [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign pop = (cnt_reg != 2'd0) && m_ready;

    always_comb begin
        logic [1:0] cnt_v;
        slot_next[0] = slot_reg[0];
        slot_next[1] = slot_reg[1];
        cnt_v        = cnt_reg;
        // Advance the queue on a taken beat
        if (pop) begin
            slot_next[0] = slot_reg[1];
            cnt_v        = cnt_reg - 2'd1;
        end
        if (push.count != 2'd0) begin
            slot_next[cnt_v[0]] = push.res0;
        end
        if (push.count == 2'd2) begin
            slot_next[1] = push.res1;
        end
        cnt_next = cnt_v + push.count;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
    end

    assign count   = cnt_reg;
    assign m_valid = (cnt_reg != 2'd0);
    assign m_data  = slot_reg[0];

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, cnt_reg} + {1'b0, push.count}) <= {1'b0, OBUF_DEPTH})
        else $error("result buffer overflow");

    a_eos_closes_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.end_of_string) |-> m_data.last_of_run)
        else $error("end of string without end of run");

endmodule

`default_nettype wire
